>>> src/move_instruction_executor_unit_defines.svh
// assertion macros used by the executor rtl (mie_exec)
// no dependencies; the using module supplies clk_i and rst_ni
`ifndef MOVE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define MOVE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mie_pkg.sv
// types and constants of the move instruction executor
// no dependencies
package mie_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PC_W    = 16;
  localparam int unsigned DSIZE_W = 9;
  localparam int unsigned BOUND_W = 17;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned PADDR_W = 3;

  localparam logic [DSIZE_W-1:0] DATA_SIZE_RESET = 9'd256;

  // opcodes
  localparam logic [CMD_W-1:0] OP_NOP      = 8'd0;
  localparam logic [CMD_W-1:0] OP_HOSTCALL = 8'd1;
  localparam logic [CMD_W-1:0] OP_MVI_IND  = 8'd2;
  localparam logic [CMD_W-1:0] OP_MVI_DIR  = 8'd3;
  localparam logic [CMD_W-1:0] OP_MV       = 8'd4;

  // register index, taken from paddr[2]
  localparam logic REG_PROGRAM_SIZE = 1'b0;
  localparam logic REG_DATA_SIZE    = 1'b1;

  typedef enum logic [2:0] {
    EXC_NONE     = 3'd0,
    EXC_RD_FAULT = 3'd1,
    EXC_WR_FAULT = 3'd2,
    EXC_HOSTCALL = 3'd3,
    EXC_BAD_OP   = 3'd4,
    EXC_PROG_END = 3'd5
  } exc_code_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_IND_WR,
    S_MV_SRC,
    S_MV_VAL,
    S_MV_WR
  } exec_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        exc_code;
    logic [DATA_W-1:0] exc_value;
    logic [PC_W-1:0]   prog_counter;
  } out_item_t;

  typedef struct packed {
    logic [PC_W-1:0]    program_size;
    logic [BOUND_W-1:0] bound;
  } cfg_t;

endpackage

>>> src/mie_ram.sv
// generic single-port ram with registered read
// no dependencies
module mie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mie_cfg.sv
// apb register block: program size and data size
// depends on mie_pkg
module mie_cfg #(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mie_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output mie_pkg::cfg_t                 cfg_o
);
  import mie_pkg::*;

  logic [PC_W-1:0]    prog_size_q, prog_size_d;
  logic [DSIZE_W-1:0] data_size_q, data_size_d;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_comb begin
    prog_size_d = prog_size_q;
    data_size_d = data_size_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PROGRAM_SIZE: prog_size_d = pwdata[PC_W-1:0];
        REG_DATA_SIZE:    data_size_d = pwdata[DSIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_size_q <= '0;
      data_size_q <= DATA_SIZE_RESET;
    end else begin
      prog_size_q <= prog_size_d;
      data_size_q <= data_size_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROGRAM_SIZE: prdata = {{(32-PC_W){1'b0}}, prog_size_q};
      REG_DATA_SIZE:    prdata = {{(32-DSIZE_W){1'b0}}, data_size_q};
      default:          prdata = '0;
    endcase
  end

  // valid address bound, data size capped at the memory depth
  always_comb begin
    cfg_o.program_size = prog_size_q;
    if ({{(BOUND_W-DSIZE_W){1'b0}}, data_size_q} > BOUND_W'(DATA_DEPTH)) begin
      cfg_o.bound = BOUND_W'(DATA_DEPTH);
    end else begin
      cfg_o.bound = {{(BOUND_W-DSIZE_W){1'b0}}, data_size_q};
    end
  end

endmodule

>>> src/mie_exec.sv
// instruction sequencer: pc, exception registers, ram accesses, result register
// depends on mie_pkg and the assertion macro header
`include "move_instruction_executor_unit_defines.svh"

module mie_exec #(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mie_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  input  mie_pkg::in_item_t        in_item_i,
  output logic                     consume_o,
  output logic                     ram_we_o,
  output logic                     ram_re_o,
  output logic [((DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1)-1:0] ram_addr_o,
  output logic [mie_pkg::DATA_W-1:0] ram_wdata_o,
  input  logic [mie_pkg::DATA_W-1:0] ram_rdata_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mie_pkg::out_item_t       out_item_o
);
  import mie_pkg::*;

  localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  exec_state_e       state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  exc_code_e         exc_code_q, exc_code_d;
  logic [DATA_W-1:0] exc_value_q, exc_value_d;
  logic [DATA_W-1:0] tgt_q, tgt_d;
  logic              rd_fault_q, rd_fault_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic              out_free;
  logic              finish;
  logic [DATA_W-1:0] rd_val;
  logic              rd_req, wr_req;
  logic [DATA_W-1:0] rd_addr, wr_addr, wr_data;

  function automatic logic in_range(logic [DATA_W-1:0] a, logic [BOUND_W-1:0] b);
    return a < {{(DATA_W-BOUND_W){1'b0}}, b};
  endfunction

  assign out_free = ~out_valid_q | ~out_stall_i;
  // a faulted read yields zero
  assign rd_val   = rd_fault_q ? '0 : ram_rdata_i;

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    exc_code_d  = exc_code_q;
    exc_value_d = exc_value_q;
    tgt_d       = tgt_q;
    rd_fault_d  = rd_fault_q;
    clr_cnt_d   = clr_cnt_q;
    finish      = 1'b0;
    rd_req      = 1'b0;
    wr_req      = 1'b0;
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = '0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = '0;
    ram_wdata_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = clr_cnt_q;
        clr_cnt_d  = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DATA_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (pc_q >= cfg_i.program_size) begin
            if (out_free) begin
              finish      = 1'b1;
              exc_code_d  = EXC_PROG_END;
              exc_value_d = {{(DATA_W-PC_W){1'b0}}, pc_q};
            end
          end else begin
            unique case (in_item_i.cmd)
              OP_MVI_IND: begin
                pc_d    = pc_q + PC_W'(1);
                rd_req  = 1'b1;
                rd_addr = in_item_i.operand_a;
                state_d = S_IND_WR;
              end
              OP_MV: begin
                pc_d    = pc_q + PC_W'(1);
                rd_req  = 1'b1;
                rd_addr = in_item_i.operand_a;
                state_d = S_MV_SRC;
              end
              OP_NOP: begin
                if (out_free) begin
                  finish = 1'b1;
                  pc_d   = pc_q + PC_W'(1);
                end
              end
              OP_HOSTCALL: begin
                if (out_free) begin
                  finish      = 1'b1;
                  pc_d        = pc_q + PC_W'(1);
                  exc_code_d  = EXC_HOSTCALL;
                  exc_value_d = in_item_i.operand_a;
                end
              end
              OP_MVI_DIR: begin
                if (out_free) begin
                  finish  = 1'b1;
                  pc_d    = pc_q + PC_W'(1);
                  wr_req  = 1'b1;
                  wr_addr = in_item_i.operand_a;
                  wr_data = in_item_i.operand_b;
                end
              end
              default: begin
                if (out_free) begin
                  finish      = 1'b1;
                  pc_d        = pc_q + PC_W'(1);
                  exc_code_d  = EXC_BAD_OP;
                  exc_value_d = {{(DATA_W-CMD_W){1'b0}}, in_item_i.cmd};
                end
              end
            endcase
          end
        end
      end
      S_IND_WR: begin
        if (out_free) begin
          finish  = 1'b1;
          wr_req  = 1'b1;
          wr_addr = rd_val;
          wr_data = in_item_i.operand_b;
          state_d = S_IDLE;
        end
      end
      S_MV_SRC: begin
        tgt_d   = rd_val;
        rd_req  = 1'b1;
        rd_addr = in_item_i.operand_b;
        state_d = S_MV_VAL;
      end
      S_MV_VAL: begin
        rd_req  = 1'b1;
        rd_addr = rd_val;
        state_d = S_MV_WR;
      end
      S_MV_WR: begin
        if (out_free) begin
          finish  = 1'b1;
          wr_req  = 1'b1;
          wr_addr = tgt_q;
          wr_data = rd_val;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // bounds check of the one access of this cycle
    if (rd_req) begin
      if (in_range(rd_addr, cfg_i.bound)) begin
        ram_re_o   = 1'b1;
        ram_addr_o = rd_addr[AW-1:0];
        rd_fault_d = 1'b0;
      end else begin
        rd_fault_d  = 1'b1;
        exc_code_d  = EXC_RD_FAULT;
        exc_value_d = rd_addr;
      end
    end
    if (wr_req) begin
      if (in_range(wr_addr, cfg_i.bound)) begin
        ram_we_o    = 1'b1;
        ram_addr_o  = wr_addr[AW-1:0];
        ram_wdata_o = wr_data;
      end else begin
        exc_code_d  = EXC_WR_FAULT;
        exc_value_d = wr_addr;
      end
    end
  end

  assign out_valid_d = finish | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= '0;
      exc_code_q  <= EXC_NONE;
      exc_value_q <= '0;
      rd_fault_q  <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      exc_code_q  <= exc_code_d;
      exc_value_q <= exc_value_d;
      rd_fault_q  <= rd_fault_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    if (finish) begin
      out_q.exc_code     <= exc_code_d;
      out_q.exc_value    <= exc_value_d;
      out_q.prog_counter <= pc_d;
    end
  end

  assign consume_o   = finish;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MIE_ASSERT_NOW(a_no_item_in_clear, state_q == S_CLEAR, !finish, "item finished during clear")
  `MIE_ASSERT_NOW(a_wr_in_bound, ram_we_o && state_q != S_CLEAR,
                  BOUND_W'(ram_addr_o) < cfg_i.bound, "ram write outside valid bound")
  `MIE_ASSERT_NOW(a_pc_step, pc_d != pc_q, pc_d == pc_q + PC_W'(1), "pc moved by more than one")
  `MIE_ASSERT_NEXT(a_finish_shows, finish, out_valid_q, "finished item not presented")

endmodule

>>> src/move_instruction_executor_unit.sv
// top level of the move instruction executor
// depends on mie_pkg, mie_cfg, mie_exec and mie_ram
//
//  port group   direction  handshake                 payload
//  in           to block   in_valid_i / in_stall_o   in_data_i  (cmd, operand_a, operand_b)
//  out          from block out_valid_o / out_stall_i out_data_o (exc_code, exc_value, prog_counter)
//  apb          to block   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// nop, hostcall, mvi direct, unknown opcode and program end finish in the idle step; mvi
//   indirect adds S_IND_WR, mv adds S_MV_SRC, S_MV_VAL, S_MV_WR (single ram port, registered read)
// after reset the ram is swept to zero, word by word, while no item is executed;
//   register writes are taken throughout
// an input register takes the next item while a result waits in the output register
// a stalled output holds the sequencer in its last step, so nothing is lost
module move_instruction_executor_unit #(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mie_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mie_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mie_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mie_pkg::*;

  localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  // input register
  logic      in_valid_q, in_valid_d;
  in_item_t  in_q;
  logic      in_accept;
  logic      consume;

  cfg_t              cfg;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // item leaves the input register only when its result is written
  assign in_stall_o = in_valid_q & ~consume;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_accept | (in_valid_q & ~consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // program size and capped data bound
  mie_cfg #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer and result register
  mie_exec #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_q),
    .in_item_i   (in_q),
    .consume_o   (consume),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

  // data memory
  mie_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

>>> bench/mie_checker.sv
// result checker for the move instruction executor: predicts each result from
// the accepted instructions and register writes, then compares in order
// depends on mie_pkg
module mie_checker
  import mie_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [31:0]         pwdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output logic [PC_W-1:0]     model_pc_o
);

  logic [PC_W-1:0]    prog_size_q;
  logic [DSIZE_W-1:0] data_size_q;
  logic [PC_W-1:0]    pc_q;
  logic [DATA_W-1:0]  mem_q [DATA_DEPTH];
  exc_code_e          exc_code_q;
  logic [DATA_W-1:0]  exc_value_q;
  out_item_t          result_q [$];

  // a data size above the depth acts as the depth
  function automatic int unsigned word_limit();
    return (data_size_q > DATA_DEPTH) ? DATA_DEPTH : int'(data_size_q);
  endfunction

  function automatic logic [DATA_W-1:0] load_word(input logic [DATA_W-1:0] addr);
    if (addr >= word_limit()) begin
      exc_code_q  = EXC_RD_FAULT;
      exc_value_q = addr;
      return '0;
    end
    return mem_q[addr];
  endfunction

  function automatic void store_word(input logic [DATA_W-1:0] addr,
                                     input logic [DATA_W-1:0] val);
    if (addr >= word_limit()) begin
      exc_code_q  = EXC_WR_FAULT;
      exc_value_q = addr;
    end else begin
      mem_q[addr] = val;
    end
  endfunction

  function automatic out_item_t execute_instr(input in_item_t instr);
    out_item_t   res;
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] val;
    if (pc_q >= prog_size_q) begin
      exc_code_q  = EXC_PROG_END;
      exc_value_q = DATA_W'(pc_q);
    end else begin
      pc_q = pc_q + 1'b1;
      case (instr.cmd)
        OP_NOP: begin
        end
        OP_HOSTCALL: begin
          exc_code_q  = EXC_HOSTCALL;
          exc_value_q = instr.operand_a;
        end
        OP_MVI_IND: begin
          tgt = load_word(instr.operand_a);
          store_word(tgt, instr.operand_b);
        end
        OP_MVI_DIR: begin
          store_word(instr.operand_a, instr.operand_b);
        end
        OP_MV: begin
          tgt = load_word(instr.operand_a);
          src = load_word(instr.operand_b);
          val = load_word(src);
          store_word(tgt, val);
        end
        default: begin
          exc_code_q  = EXC_BAD_OP;
          exc_value_q = DATA_W'(instr.cmd);
        end
      endcase
    end
    res.exc_code     = exc_code_q;
    res.exc_value    = exc_value_q;
    res.prog_counter = pc_q;
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    bit        ok;
    if (!rst_ni) begin
      prog_size_q  = '0;
      data_size_q  = DATA_SIZE_RESET;
      pc_q         = '0;
      exc_code_q   = EXC_NONE;
      exc_value_q  = '0;
      fail_count_o = 0;
      foreach (mem_q[i]) mem_q[i] = '0;
      result_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_PROGRAM_SIZE) prog_size_q = pwdata_i[PC_W-1:0];
        else data_size_q = pwdata_i[DSIZE_W-1:0];
      end
      // compare before pushing, a result never belongs to an item of the same edge
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, actual code %0d value 0x%h pc %0d", $time,
                   out_data_i.exc_code, out_data_i.exc_value, out_data_i.prog_counter);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          ok = field_ok("exc_code", DATA_W'(want.exc_code), DATA_W'(out_data_i.exc_code))
             & field_ok("exc_value", want.exc_value, out_data_i.exc_value)
             & field_ok("prog_counter", DATA_W'(want.prog_counter),
                        DATA_W'(out_data_i.prog_counter));
          if (!ok) fail_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(execute_instr(in_data_i));
    end
    pending_o  = result_q.size();
    model_pc_o = pc_q;
  end

endmodule

>>> bench/tb_top.sv
// testbench top for the move instruction executor: clock, reset, instruction
// and register stimulus, random output stalls, watchdog and verdict
// depends on mie_pkg, mie_checker and the executor rtl
module tb_top;
  import mie_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned END_CYCLES = 20;

  // opcodes outside the defined set
  localparam logic [CMD_W-1:0] BAD_OP_LO  = OP_MV + 1'b1;
  localparam logic [CMD_W-1:0] BAD_OP_TOP = '1;

  // every input known from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned        fail_count;
  int unsigned        pending;
  logic [PC_W-1:0]    model_pc;

  int unsigned        sent_count    = 0;
  int unsigned        setting_count = 0;
  int unsigned        idle_cycles   = 0;
  int unsigned        addr_lim      = DEPTH;
  bit                 gaps_on       = 1'b1;

  move_instruction_executor_unit #(
    .DATA_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mie_checker #(
    .DATA_DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .model_pc_o  (model_pc)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver side: runs with no stall, runs of sparse stalls, now and then a long stall
  initial begin
    int unsigned r;
    int unsigned len;
    @(posedge clk);
    forever begin
      r = $urandom_range(99);
      if (r < 35) begin
        len = $urandom_range(40, 5);
        repeat (len) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end else if (r < 95) begin
        len = $urandom_range(30, 5);
        repeat (len) begin
          out_stall <= ($urandom_range(3) == 0);
          @(posedge clk);
        end
      end else begin
        len = $urandom_range(60, 20);
        repeat (len) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // watchdog: any accepted item, result or register write restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t mk(input logic [CMD_W-1:0] cmd,
                                  input logic [DATA_W-1:0] opa,
                                  input logic [DATA_W-1:0] opb);
    in_item_t instr;
    instr.cmd       = cmd;
    instr.operand_a = opa;
    instr.operand_b = opb;
    return instr;
  endfunction

  // mostly inside or just past the valid window, sometimes anywhere
  function automatic logic [DATA_W-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return DATA_W'($urandom_range(addr_lim));
    if (r < 92) return DATA_W'($urandom_range(DEPTH + 3));
    return $urandom();
  endfunction

  // pointer-like values keep indirect moves landing in memory most of the time
  function automatic in_item_t random_instr();
    in_item_t    instr;
    int unsigned r;
    r = $urandom_range(99);
    instr.operand_a = pick_addr();
    instr.operand_b = ($urandom_range(9) < 6) ? pick_addr() : $urandom();
    if (r < 8) begin
      instr.cmd = OP_NOP;
    end else if (r < 16) begin
      instr.cmd       = OP_HOSTCALL;
      instr.operand_a = $urandom();
    end else if (r < 40) begin
      instr.cmd = OP_MVI_DIR;
    end else if (r < 58) begin
      instr.cmd = OP_MVI_IND;
    end else if (r < 88) begin
      instr.cmd       = OP_MV;
      instr.operand_b = pick_addr();
    end else if (r < 95) begin
      instr.cmd = CMD_W'($urandom_range(BAD_OP_TOP, BAD_OP_LO));
    end else begin
      // raw noise, any opcode and operands
      instr.cmd       = CMD_W'($urandom());
      instr.operand_a = $urandom();
      instr.operand_b = $urandom();
    end
    return instr;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // entered at a rising edge, returns at the edge where the item was taken;
  // valid stays high so a back-to-back item needs no second assignment
  task automatic issue(input in_item_t instr);
    int unsigned gap;
    logic        stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= instr;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent_count++;
  endtask

  // pending is sampled at the falling edge, away from the rtl's update
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // setup phase then access phase, then an idle gap so psel never toggles twice
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only once every result is back; the program size can be
  // given relative to the current counter so program end lands mid-phase
  task automatic configure(input logic [PC_W-1:0] psize, input logic [DSIZE_W-1:0] dsize,
                           input bit from_pc);
    logic [PC_W-1:0] ps;
    in_valid <= 1'b0;
    wait_drained();
    ps = from_pc ? psize + model_pc : psize;
    // upper data bits are don't-care, so fill them with noise
    write_reg(REG_PROGRAM_SIZE, {16'($urandom()), ps});
    write_reg(REG_DATA_SIZE, {23'($urandom()), dsize});
    addr_lim = (dsize > DEPTH) ? DEPTH : int'(dsize);
    setting_count++;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) issue(random_instr());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // program size still zero after reset: program end at counter zero,
    // taken once the ram sweep lets items in
    issue(mk(OP_NOP, '0, '0));
    issue(mk(OP_MV, '0, '0));

    configure('1, DATA_SIZE_RESET, 1'b0);
    issue(mk(OP_NOP, '0, '1));
    issue(mk(OP_HOSTCALL, '1, '0));
    issue(mk(OP_MVI_DIR, '0, '1));
    issue(mk(OP_MVI_DIR, DEPTH - 1, 32'h1));
    issue(mk(OP_MVI_DIR, DEPTH, 32'h5));          // just past the end, write fault
    issue(mk(OP_MVI_DIR, '1, 32'h5));             // top address, write fault
    issue(mk(OP_MVI_DIR, 32'd1, DEPTH - 1));
    issue(mk(OP_MVI_IND, 32'd1, 32'hA5A5_A5A5));  // through a pointer to the last word
    issue(mk(OP_MVI_IND, '0, 32'h3));             // pointer holds all ones, write fault
    issue(mk(OP_MVI_IND, 32'd300, 32'd2));        // read fault yields zero, write still lands
    issue(mk(OP_MVI_DIR, 32'd2, 32'd7));
    issue(mk(OP_MV, 32'd1, '0));                  // double-indirect copy, value pointer 2: copies 7 to the last word
    issue(mk(OP_MVI_DIR, 32'd3, 32'd1000));
    issue(mk(OP_MV, 32'd1, 32'd3));               // source data pointer out of range
    issue(mk(OP_MV, 32'd400, 32'd500));           // two read faults, the later one wins
    issue(mk(OP_MV, 32'd2, '1));
    issue(mk(BAD_OP_LO, '1, '1));
    issue(mk(BAD_OP_TOP, '0, '0));
    issue(mk(OP_HOSTCALL, '0, '1));

    // zero data size: every access faults
    configure('1, '0, 1'b0);
    issue(mk(OP_MVI_DIR, '0, 32'd1));
    issue(mk(OP_MV, '0, '0));

    // data size above the depth acts as the depth
    configure('1, 9'd300, 1'b0);
    issue(mk(OP_MVI_DIR, DEPTH - 1, 32'd9));
    issue(mk(OP_MVI_DIR, DEPTH, 32'd9));

    // program end two items from now, counter then holds
    configure(16'd2, DATA_SIZE_RESET, 1'b0 | 1'b1);
    repeat (4) issue(random_instr());

    // random phases; every register setting starts from a drained block
    configure('1, DATA_SIZE_RESET, 1'b0);
    run_random(170);
    gaps_on = 1'b0;
    configure('1, 9'd16, 1'b0);
    run_random(170);
    gaps_on = 1'b1;
    configure('1, '0, 1'b0);
    run_random(80);
    configure(16'd70, '1, 1'b1);
    run_random(160);
    configure('0, 9'd1, 1'b0);
    run_random(30);
    configure('1, 9'd300, 1'b0);
    run_random(170);
    configure(PC_W'($urandom_range(400, 150)), DSIZE_W'($urandom_range(255, 2)), 1'b1);
    run_random(200);
    gaps_on = 1'b0;
    configure('1, DATA_SIZE_RESET, 1'b0);
    run_random(100);
    gaps_on = 1'b1;
    run_random(100);

    in_valid <= 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("run covered %0d instructions over %0d register settings, counter at %0d",
             sent_count, setting_count, model_pc);
    $display("data sizes 0 to 511, program end, faults, hostcalls and bad opcodes exercised");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d results mismatched", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
